[hdl/utf16_to_utf8_transcoder_core_defines.svh]
// Assertion macros shared by the transcoder checker.
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define UTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define UTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

[hdl/utt_pkg.sv]
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
`default_nettype none
package utt_pkg;

  // Status codes reported on the end-of-stream result
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ODD      = 3'd1,
    ST_MISSING  = 3'd2,
    ST_BAD_LOW  = 3'd3,
    ST_LONE_LOW = 3'd4
  } status_t;

  // Result kinds
  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Register map
  localparam logic REG_LITTLE_ENDIAN = 1'b0;

  // Surrogate prefixes (top six bits of a unit)
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // One queued job: up to four encoded bytes and an optional status
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            has_status;
    status_t         status;
    logic            zero_stop;
  } job_t;

endpackage
`default_nettype wire

[hdl/utt_front.sv]
// Front end: pairs bytes into units, tracks surrogates and encodes code points.
`default_nettype none
module utt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          little_endian,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          byte_present,
  input  wire logic          end_of_stream,
  input  wire logic          q_full,
  output logic               push,
  output utt_pkg::job_t      push_job
);
  import utt_pkg::*;

  logic [7:0] held_byte, held_byte_next;
  logic       byte_phase, byte_phase_next;
  logic [9:0] high_part, high_part_next;
  logic       surrogate_pending, surrogate_pending_next;
  logic       zero_seen, zero_seen_next;
  status_t    error_code, error_code_next;

  logic [15:0] unit;
  logic [20:0] cp;
  logic        emit;
  logic        accept;
  job_t        job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Decode one item against the stream state
  always_comb begin
    held_byte_next         = held_byte;
    byte_phase_next        = byte_phase;
    high_part_next         = high_part;
    surrogate_pending_next = surrogate_pending;
    zero_seen_next         = zero_seen;
    error_code_next        = error_code;
    unit = little_endian ? {in_byte, held_byte} : {held_byte, in_byte};
    cp   = '0;
    emit = 1'b0;
    job  = '0;

    if (byte_present) begin
      if (!byte_phase) begin
        held_byte_next  = in_byte;
        byte_phase_next = 1'b1;
      end else begin
        byte_phase_next = 1'b0;
        if (error_code == ST_OK && !zero_seen) begin
          if (surrogate_pending) begin
            surrogate_pending_next = 1'b0;
            high_part_next         = '0;
            if (unit[15:10] == LOW_SURR_TAG) begin
              cp   = SUPP_BASE + 21'({high_part, unit[9:0]});
              emit = 1'b1;
            end else begin
              error_code_next = ST_BAD_LOW;
            end
          end else if (unit == 16'd0) begin
            zero_seen_next = 1'b1;
          end else if (unit[15:10] == HIGH_SURR_TAG) begin
            surrogate_pending_next = 1'b1;
            high_part_next         = unit[9:0];
          end else if (unit[15:10] == LOW_SURR_TAG) begin
            error_code_next = ST_LONE_LOW;
          end else begin
            cp   = 21'(unit);
            emit = 1'b1;
          end
        end
      end
    end

    // Encode the code point as UTF-8
    if (emit) begin
      if (cp[20:7] == '0) begin
        job.nbytes   = 3'd1;
        job.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp[20:11] == '0) begin
        job.nbytes   = 3'd2;
        job.bytes[0] = {3'b110, cp[10:6]};
        job.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp[20:16] == '0) begin
        job.nbytes   = 3'd3;
        job.bytes[0] = {4'b1110, cp[15:12]};
        job.bytes[1] = {2'b10, cp[11:6]};
        job.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        job.nbytes   = 3'd4;
        job.bytes[0] = {5'b11110, cp[20:18]};
        job.bytes[1] = {2'b10, cp[17:12]};
        job.bytes[2] = {2'b10, cp[11:6]};
        job.bytes[3] = {2'b10, cp[5:0]};
      end
    end

    // Build the status and clear the stream at its end
    if (end_of_stream) begin
      job.has_status = 1'b1;
      if (byte_phase_next) begin
        job.status = ST_ODD;
      end else if (error_code_next != ST_OK) begin
        job.status = error_code_next;
      end else if (surrogate_pending_next) begin
        job.status = ST_MISSING;
      end else begin
        job.status    = ST_OK;
        job.zero_stop = zero_seen_next;
      end
      held_byte_next         = '0;
      byte_phase_next        = 1'b0;
      high_part_next         = '0;
      surrogate_pending_next = 1'b0;
      zero_seen_next         = 1'b0;
      error_code_next        = ST_OK;
    end
  end

  assign push     = accept && (emit || end_of_stream);
  assign push_job = job;

  // Update stream state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte         <= '0;
      byte_phase        <= 1'b0;
      high_part         <= '0;
      surrogate_pending <= 1'b0;
      zero_seen         <= 1'b0;
      error_code        <= ST_OK;
    end else if (accept) begin
      held_byte         <= held_byte_next;
      byte_phase        <= byte_phase_next;
      high_part         <= high_part_next;
      surrogate_pending <= surrogate_pending_next;
      zero_seen         <= zero_seen_next;
      error_code        <= error_code_next;
    end
  end

endmodule
`default_nettype wire

[hdl/utt_queue.sv]
// Short job queue between the front end and the output serializer.
`default_nettype none
module utt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire utt_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output utt_pkg::job_t      head,
  output logic               empty
);
  import utt_pkg::*;

  job_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;

  assign full  = count == (QAW+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/utt_back.sv]
// Back end: walks each queued job; one result per cycle while out_ready is high.
`default_nettype none
module utt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire utt_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               result_kind,
  output logic [7:0]         utf8_byte,
  output logic [2:0]         status,
  output logic               stopped_at_zero,
  output logic               run_last
);
  import utt_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic       last;
  logic       is_data;
  logic       load;

  assign total   = head.nbytes + {2'b00, head.has_status};
  assign last    = idx == (total - 3'd1);
  assign is_data = idx < head.nbytes;
  assign load    = !empty && (!out_valid || out_ready);
  assign pop     = load && last;

  // Step through the results of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      run_last <= last;
      if (is_data) begin
        result_kind     <= KIND_DATA;
        utf8_byte       <= head.bytes[idx[1:0]];
        status          <= ST_OK;
        stopped_at_zero <= 1'b0;
      end else begin
        result_kind     <= KIND_STATUS;
        utf8_byte       <= '0;
        status          <= head.status;
        stopped_at_zero <= head.zero_stop;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/utf16_to_utf8_transcoder_core.sv]
// Path: an accepted request's job is registered in the queue, and the back end then loads
// its first result into the output register. Throughput: the front takes a request every
// cycle while its job queue has room; the output register drains one result per cycle
// while out_ready is high; a request gives up to five results, and one with none no job.
// Reset: synchronous rst clears stream state, queue and output; little_endian goes to 1.
`default_nettype none
module utf16_to_utf8_transcoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [7:0]       utf8_byte,
  output logic [2:0]       status,
  output logic             stopped_at_zero,
  output logic             run_last
);
  import utt_pkg::*;

  logic little_endian;
  logic q_full, q_empty, push, pop;
  job_t push_job, head;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LITTLE_ENDIAN) ? {31'd0, little_endian} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LITTLE_ENDIAN) begin
      little_endian <= pwdata[0];
    end
  end

  utt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .little_endian (little_endian),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .byte_present  (byte_present),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  utt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  utt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .utf8_byte       (utf8_byte),
    .status          (status),
    .stopped_at_zero (stopped_at_zero),
    .run_last        (run_last)
  );

endmodule
`default_nettype wire

[hdl/utt_checker.sv]
// Port-level checker for the transcoder, bound to the top level.
`default_nettype none
`include "utf16_to_utf8_transcoder_core_defines.svh"
module utt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       result_kind,
  input wire logic [7:0] utf8_byte,
  input wire logic [2:0] status,
  input wire logic       stopped_at_zero,
  input wire logic       run_last
);
  import utt_pkg::*;

  // Hold a stalled result
  `UTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(utf8_byte))

  // Data results carry no status
  `UTT_ASSERT_NOW(a_data_clean, out_valid && result_kind == KIND_DATA, status == ST_OK && !stopped_at_zero)

  // A status result closes its request and carries no byte
  `UTT_ASSERT_NOW(a_status_last, out_valid && result_kind == KIND_STATUS, run_last && utf8_byte == 8'd0)

  // Zero stop only reported with an ok status
  `UTT_ASSERT_NOW(a_zero_ok, out_valid && stopped_at_zero, result_kind == KIND_STATUS && status == ST_OK)

endmodule

bind utf16_to_utf8_transcoder_core utt_checker u_utt_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .result_kind     (result_kind),
  .utf8_byte       (utf8_byte),
  .status          (status),
  .stopped_at_zero (stopped_at_zero),
  .run_last        (run_last)
);
`default_nettype wire
